FILE: hw/rtl/fbgf_pkg.sv
// fbgf_pkg: shared types and constants for the bin gain filter
// twiddle table and sequencer state encoding; no dependencies
`default_nettype none

package fbgf_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FWD,
    ST_GAIN,
    ST_INV,
    ST_EMIT
  } state_e;

  // quarter-wave cosine table, 2^15 scale, index 0..16
  function automatic logic signed [17:0] cos_q(input logic [4:0] idx);
    logic signed [17:0] r;
    case (idx)
      5'd0:  r = 18'sd32768;
      5'd1:  r = 18'sd32610;
      5'd2:  r = 18'sd32138;
      5'd3:  r = 18'sd31357;
      5'd4:  r = 18'sd30274;
      5'd5:  r = 18'sd28899;
      5'd6:  r = 18'sd27246;
      5'd7:  r = 18'sd25330;
      5'd8:  r = 18'sd23170;
      5'd9:  r = 18'sd20788;
      5'd10: r = 18'sd18205;
      5'd11: r = 18'sd15447;
      5'd12: r = 18'sd12540;
      5'd13: r = 18'sd9512;
      5'd14: r = 18'sd6393;
      5'd15: r = 18'sd3212;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // full-circle cosine over 64 phases
  function automatic logic signed [17:0] cos64(input logic [5:0] m);
    logic signed [17:0] r;
    logic [6:0] mm;
    mm = {1'b0, m};
    if (mm <= 7'd16) begin
      r = cos_q(mm[4:0]);
    end else if (mm <= 7'd32) begin
      r = -cos_q(5'(7'd32 - mm));
    end else if (mm <= 7'd48) begin
      r = -cos_q(5'(mm - 7'd32));
    end else begin
      r = cos_q(5'(7'd64 - mm));
    end
    return r;
  endfunction

  function automatic logic signed [17:0] sin64(input logic [5:0] m);
    return cos64(6'(m + 6'd48));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fft_bin_gain_filter_unit.sv
// fft_bin_gain_filter_unit: top level of the frequency-domain bin gain filter
// depends on fbgf_pkg and fbgf_ram
`default_nettype none

// Loads N = 2^log2_length complex samples with per-bin gains, then runs a
// forward DFT and an inverse DFT on one shared complex multiply-accumulate
// unit, with a per-bin gain multiply between them, and emits N results.
// Samples, gains and the gained spectrum live in three synchronous rams. Each
// DFT output term reads one ram word per accumulate term, fills the read and
// multiply registers and then rounds. Each forward bin then has its gain
// applied, and each time sample is emitted under the output handshake.
// Loading takes one item per cycle while no configuration write is pending,
// and no item is taken while a block is computed or emitted.
// A length of one passes the sample straight through.
module fft_bin_gain_filter_unit #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [2:0]                    cfg_log2_length_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  input  wire logic signed [15:0]            bin_gain_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      time_real_o,
  output logic signed [SAMPLE_BITS-1:0]      time_imag_o,
  output logic signed [SAMPLE_BITS-1:0]      freq_real_o,
  output logic signed [SAMPLE_BITS-1:0]      freq_imag_o,
  output logic                               last_of_block_o
);
  import fbgf_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int MAXL = $clog2(MAX_POINTS + 1) - 1;
  localparam int CW = AW + 1;
  localparam int WB = SAMPLE_BITS + MAXL + 2;   // gained spectrum word width
  localparam int AB = WB + MAXL + 18;           // accumulator width
  localparam int SB = 2 * SAMPLE_BITS;

  state_e state_q, state_d;
  logic [2:0]    log_q;
  logic [CW-1:0] load_q;
  logic [AW-1:0] k_q, n_q;              // outer index, inner term index
  logic          phase_q;               // inner terms issued
  logic [1:0]    tail_q;                // gain and emit step counter
  logic          rd_v_q;                // read in flight
  logic [AW-1:0] rd_n_q;
  logic signed [AB-1:0] acc_re_q, acc_im_q;
  logic signed [WB-1:0] fr_q, fi_q;     // rounded forward bin

  // effective length exponent
  logic [2:0] l_eff;
  always_comb begin
    l_eff = log_q;
    if ({29'd0, log_q} > MAXL) l_eff = 3'(MAXL);
  end
  logic [CW-1:0] npts;
  assign npts = CW'(1) << l_eff;
  logic [AW-1:0] last_idx;
  assign last_idx = AW'(npts - CW'(1));

  // rams
  logic          s_we, g_we, w_we;
  logic [AW-1:0] s_ra, g_ra, w_ra, w_wa;
  logic [SB-1:0] s_rd;
  logic [15:0]   g_rd;
  logic [2*WB-1:0] w_rd, w_wd;

  assign s_we = in_valid_i && in_ready_o;
  assign g_we = s_we;

  fbgf_ram #(.Width(SB), .Depth(MAX_POINTS)) u_sample (
    .clk_i, .we_i(s_we), .waddr_i(load_q[AW-1:0]),
    .wdata_i({sample_real_i, sample_imag_i}), .raddr_i(s_ra), .rdata_o(s_rd));
  fbgf_ram #(.Width(16), .Depth(MAX_POINTS)) u_gain (
    .clk_i, .we_i(g_we), .waddr_i(load_q[AW-1:0]),
    .wdata_i(bin_gain_i), .raddr_i(g_ra), .rdata_o(g_rd));
  fbgf_ram #(.Width(2*WB), .Depth(MAX_POINTS)) u_work (
    .clk_i, .we_i(w_we), .waddr_i(w_wa),
    .wdata_i(w_wd), .raddr_i(w_ra), .rdata_o(w_rd));

  // twiddle phase of the term coming back from ram
  logic [5:0] ph;
  assign ph = 6'(AW'(k_q * rd_n_q) & last_idx) << (3'd6 - l_eff);
  logic signed [17:0] tc, ts;
  assign tc = cos64(ph);
  assign ts = sin64(ph);

  // operand select: samples forward, work data inverse
  logic signed [WB-1:0] xr, xi;
  always_comb begin
    if (state_q == ST_FWD) begin
      xr = WB'($signed(s_rd[SB-1:SAMPLE_BITS]));
      xi = WB'($signed(s_rd[SAMPLE_BITS-1:0]));
    end else begin
      xr = $signed(w_rd[2*WB-1:WB]);
      xi = $signed(w_rd[WB-1:0]);
    end
  end

  // full width twiddle products
  logic signed [WB+17:0] m_rc, m_is, m_ic, m_rs;
  assign m_rc = xr * tc;
  assign m_is = xi * ts;
  assign m_ic = xi * tc;
  assign m_rs = xr * ts;

  // products registered before accumulate
  logic signed [AB-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic p_v_q;
  always_ff @(posedge clk_i) begin
    p_rc_q <= AB'(m_rc);
    p_is_q <= AB'(m_is);
    p_ic_q <= AB'(m_ic);
    p_rs_q <= AB'(m_rs);
  end

  // round half up then shift (arithmetic shift is floor)
  function automatic logic signed [AB-1:0] rnd(input logic signed [AB-1:0] v,
                                                input logic [4:0] s);
    logic signed [AB-1:0] t;
    t = v;
    if (s != 5'd0) t = v + (AB'(1) <<< (s - 5'd1));
    return t >>> s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [AB-1:0] v);
    logic signed [AB-1:0] hi, lo;
    hi = AB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    lo = -hi - AB'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  // gain multiply, registered
  logic signed [WB+15:0] m_gr, m_gi;
  assign m_gr = fr_q * $signed(g_rd);
  assign m_gi = fi_q * $signed(g_rd);
  logic signed [AB-1:0] gr_q, gi_q;
  always_ff @(posedge clk_i) begin
    gr_q <= AB'(m_gr);
    gi_q <= AB'(m_gi);
  end

  logic issue_done;
  assign issue_done = phase_q;
  logic drained;
  assign drained = issue_done && !rd_v_q && !p_v_q;

  // read addresses
  always_comb begin
    s_ra = n_q;
    w_ra = (state_q == ST_EMIT) ? k_q : n_q;
    g_ra = k_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (s_we && (load_q + CW'(1) >= npts) && npts != CW'(1)) state_d = ST_FWD;
      ST_FWD:  if (drained) state_d = ST_GAIN;
      ST_GAIN: if (tail_q == 2'd2) state_d = (k_q == last_idx) ? ST_INV : ST_FWD;
      ST_INV:  if (drained) state_d = ST_EMIT;
      ST_EMIT: if (out_valid_o && out_ready_i && tail_q == 2'd1) begin
        state_d = last_of_block_o ? ST_LOAD : ST_INV;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs to handshakes, a register write goes ahead of a sample
  always_comb begin
    in_ready_o  = (state_q == ST_LOAD) && !out_valid_o && !cfg_valid_i;
    cfg_ready_o = (state_q == ST_LOAD) && !out_valid_o;
  end

  assign w_we = (state_q == ST_GAIN) && (tail_q == 2'd2);
  assign w_wa = k_q;
  assign w_wd = {WB'(rnd(gr_q, 5'd14)), WB'(rnd(gi_q, 5'd14))};

  logic signed [SAMPLE_BITS-1:0] tr_q, ti_q;  // time sample for the current outer index

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      log_q <= 3'd6;
      load_q <= '0;
      k_q <= '0;
      n_q <= '0;
      phase_q <= 1'b0;
      tail_q <= '0;
      rd_v_q <= 1'b0;
      p_v_q <= 1'b0;
      out_valid_o <= 1'b0;
      last_of_block_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q <= ((state_q == ST_FWD) || (state_q == ST_INV)) && !phase_q;
      p_v_q <= rd_v_q;
      rd_n_q <= n_q;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (cfg_valid_i && cfg_ready_o) begin
            log_q <= cfg_log2_length_i;
            load_q <= '0;
          end else if (s_we) begin
            if (load_q + CW'(1) >= npts) begin
              load_q <= '0;
              if (npts == CW'(1)) begin
                time_real_o <= sample_real_i;
                time_imag_o <= sample_imag_i;
                freq_real_o <= sample_real_i;
                freq_imag_o <= sample_imag_i;
                last_of_block_o <= 1'b1;
                out_valid_o <= 1'b1;
              end
            end else begin
              load_q <= load_q + CW'(1);
            end
          end
          k_q <= '0; n_q <= '0; phase_q <= 1'b0;
          acc_re_q <= '0; acc_im_q <= '0; tail_q <= '0;
        end
        ST_FWD, ST_INV: begin
          if (!phase_q) begin
            if (n_q == last_idx) phase_q <= 1'b1;
            n_q <= (n_q == last_idx) ? '0 : n_q + AW'(1);
          end
          if (p_v_q) begin
            if (state_q == ST_FWD) begin
              acc_re_q <= acc_re_q + p_rc_q + p_is_q;
              acc_im_q <= acc_im_q + p_ic_q - p_rs_q;
            end else begin
              acc_re_q <= acc_re_q + p_rc_q - p_is_q;
              acc_im_q <= acc_im_q + p_ic_q + p_rs_q;
            end
          end
          if (drained) begin
            phase_q <= 1'b0;
            if (state_q == ST_FWD) begin
              fr_q <= WB'(rnd(acc_re_q, 5'd15));
              fi_q <= WB'(rnd(acc_im_q, 5'd15));
              tail_q <= '0;
            end else begin
              tr_q <= sat(rnd(acc_re_q, 5'(15 + 32'(l_eff))));
              ti_q <= sat(rnd(acc_im_q, 5'(15 + 32'(l_eff))));
              tail_q <= '0;
            end
            acc_re_q <= '0; acc_im_q <= '0;
          end
        end
        ST_GAIN: begin
          // gain read issued at entry, read data then product registered before the write
          tail_q <= (tail_q == 2'd2) ? 2'd0 : tail_q + 2'd1;
          if (tail_q == 2'd2) begin
            k_q <= (k_q == last_idx) ? '0 : k_q + AW'(1);
          end
        end
        ST_EMIT: begin
          // work read issued first, then the result is presented and held until taken
          if (tail_q == 2'd0) begin
            tail_q <= 2'd1;
          end else if (!out_valid_o) begin
            time_real_o <= tr_q;
            time_imag_o <= ti_q;
            freq_real_o <= sat(rnd(AB'($signed(w_rd[2*WB-1:WB])), 5'(l_eff)));
            freq_imag_o <= sat(rnd(AB'($signed(w_rd[WB-1:0])), 5'(l_eff)));
            last_of_block_o <= (k_q == last_idx);
            out_valid_o <= 1'b1;
          end else if (out_ready_i) begin
            tail_q <= '0;
            if (k_q != last_idx) begin
              k_q <= k_q + AW'(1);
            end else begin
              k_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fbgf_ram.sv
// fbgf_ram: generic single-port-write, single-read synchronous ram
// registered read data, no reset on contents; no dependencies
`default_nettype none

module fbgf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
